### hdl/mira_pkg.sv
// Shared types, codes and reset constants of the MSI identity range allocator.
// Depends on nothing; every other file of the block but mira_ram imports it.
package mira_pkg;

  localparam int ID_COUNT_DEF   = 2048;
  localparam int HART_COUNT_DEF = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int TBL_W      = 5;

  localparam logic [11:0] ID_LIMIT_RST    = 12'd255;
  localparam logic [63:0] FILE_BASE_RST   = 64'd0;
  localparam logic [4:0]  STRIDE_SHIFT_RST = 5'd12;
  localparam logic [4:0]  HART_COUNT_RST  = 5'd1;

  typedef enum logic [1:0] {
    CMD_ALLOC      = 2'd0,
    CMD_RESERVE    = 2'd1,
    CMD_SET_TARGET = 2'd2,
    CMD_COMPOSE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_ID_LIMIT     = 2'd0,
    CFG_FILE_BASE    = 2'd1,
    CFG_STRIDE_SHIFT = 2'd2,
    CFG_HART_COUNT   = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN_RD,
    ST_SCAN_LD,
    ST_SCAN,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_TGT,
    ST_RES_CHK,
    ST_CMP_CHK
  } state_t;

  typedef enum logic [2:0] {
    FIN_NONE,
    FIN_ALLOC_FAIL,
    FIN_ALLOC_OK,
    FIN_ECHO_FAIL,
    FIN_SET,
    FIN_RES,
    FIN_CMP
  } fin_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [11:0] run_length;
    logic [10:0] ident;
    logic [3:0]  hart;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [10:0] first_id;
    logic [63:0] msg_addr;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic clr_step;
    logic scan_init;
    logic scan_rd;
    logic scan_ld;
    logic scan_step;
    logic mark_rd;
    logic mark_wr;
    logic tgt_step;
    logic tbl_set;
    logic res_rd;
    logic res_chk;
    logic cmp_rd;
    fin_t fin;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_t cmd;
    logic clr_last;
    logic len_zero;
    logic id_bad;
    logic found;
    logic fail;
    logic word_end;
    logic mark_last;
    logic tgt_last;
  } sts_t;

endpackage

### hdl/msi_id_range_allocator.sv
// Top level of the MSI identity range allocator: controller plus datapath.
// Depends on mira_pkg, mira_ctrl, mira_dp (and mira_ram through mira_dp).
// An allocation searches the map, marks the found run word by word and then
// targets each identity of the run. One command at a time; the receiver
// cannot stall. Reset (synchronous) is followed by a clearing pass over the
// target table, during which busy stays high.
module msi_id_range_allocator
  import mira_pkg::*;
#(
  parameter int ID_COUNT   = ID_COUNT_DEF,
  parameter int HART_COUNT = HART_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Command channel: a transfer happens when start is high and busy is low.
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req,
  // Result channel: done marks the single cycle in which rsp is valid.
  output logic                  done,
  output rsp_t                  rsp,
  // Configuration write port, to be taken only while the block is idle; the block does not enforce it.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // The controller only steps the sequence; every register of payload,
  // the used-bit map and the target table live in the datapath.
  ctl_t ctl;
  sts_t sts;

  mira_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  // The search reads one 64-bit map word and then walks it eight
  // identities per cycle; a found run is marked word by word and then
  // targeted to hart zero one identity per cycle.
  mira_dp #(
    .ID_COUNT   (ID_COUNT),
    .HART_COUNT (HART_COUNT)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .ctl      (ctl),
    .sts      (sts),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .done     (done),
    .rsp      (rsp)
  );

endmodule

### hdl/mira_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module mira_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/mira_ctrl.sv
// Controller state machine of the allocator: sequences clearing, search,
// marking and table updates. Depends on mira_pkg.
module mira_ctrl
  import mira_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output ctl_t ctl,
  output logic busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:   if (sts.clr_last) state_next = ST_IDLE;
      ST_IDLE:    if (start) state_next = ST_DECODE;
      ST_DECODE: begin
        case (sts.cmd)
          CMD_ALLOC:   state_next = sts.len_zero ? ST_IDLE : ST_SCAN_RD;
          CMD_RESERVE: state_next = sts.id_bad ? ST_IDLE : ST_RES_CHK;
          CMD_COMPOSE: state_next = sts.id_bad ? ST_IDLE : ST_CMP_CHK;
          default:     state_next = ST_IDLE;
        endcase
      end
      ST_SCAN_RD: state_next = ST_SCAN_LD;
      ST_SCAN_LD: state_next = ST_SCAN;
      ST_SCAN: begin
        if (sts.found) begin
          state_next = ST_MARK_RD;
        end else if (sts.fail) begin
          state_next = ST_IDLE;
        end else if (sts.word_end) begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_MARK_RD: state_next = ST_MARK_WR;
      ST_MARK_WR: state_next = sts.mark_last ? ST_TGT : ST_MARK_RD;
      ST_TGT:     if (sts.tgt_last) state_next = ST_IDLE;
      ST_RES_CHK: state_next = ST_IDLE;
      ST_CMP_CHK: state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = (state != ST_IDLE);
    case (state)
      ST_CLEAR: ctl.clr_step = 1'b1;
      ST_IDLE:  ctl.latch = start;
      ST_DECODE: begin
        case (sts.cmd)
          CMD_ALLOC: begin
            if (sts.len_zero) begin
              ctl.fin = FIN_ALLOC_FAIL;
            end else begin
              ctl.scan_init = 1'b1;
            end
          end
          CMD_RESERVE: begin
            if (sts.id_bad) begin
              ctl.fin = FIN_ECHO_FAIL;
            end else begin
              ctl.res_rd = 1'b1;
            end
          end
          CMD_COMPOSE: begin
            if (sts.id_bad) begin
              ctl.fin = FIN_ECHO_FAIL;
            end else begin
              ctl.cmp_rd = 1'b1;
            end
          end
          default: begin
            ctl.tbl_set = 1'b1;
            ctl.fin     = FIN_SET;
          end
        endcase
      end
      ST_SCAN_RD: ctl.scan_rd = 1'b1;
      ST_SCAN_LD: ctl.scan_ld = 1'b1;
      ST_SCAN: begin
        ctl.scan_step = 1'b1;
        if (!sts.found && sts.fail) ctl.fin = FIN_ALLOC_FAIL;
      end
      ST_MARK_RD: ctl.mark_rd = 1'b1;
      ST_MARK_WR: ctl.mark_wr = 1'b1;
      ST_TGT: begin
        ctl.tgt_step = 1'b1;
        if (sts.tgt_last) ctl.fin = FIN_ALLOC_OK;
      end
      ST_RES_CHK: begin
        ctl.res_chk = 1'b1;
        ctl.fin     = FIN_RES;
      end
      ST_CMP_CHK: ctl.fin = FIN_CMP;
      default: ;
    endcase
  end

  a_start_decodes: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && start) |=> state == ST_DECODE)
    else $error("accepted transfer did not reach decode");
  a_mark_pairs: assert property (@(posedge clk) disable iff (rst)
    state == ST_MARK_RD |=> state == ST_MARK_WR)
    else $error("map read of marking pass not followed by its write");
  a_scan_loaded: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> ($past(state) == ST_SCAN_LD || $past(state) == ST_SCAN))
    else $error("scan ran on a word that was not loaded");

endmodule

### hdl/mira_dp.sv
// Datapath of the allocator: configuration registers, used-bit map, target
// table, search counters and result register. Depends on mira_pkg, mira_ram.
module mira_dp
  import mira_pkg::*;
#(
  parameter int ID_COUNT   = ID_COUNT_DEF,
  parameter int HART_COUNT = HART_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  req_t                  req,
  input  ctl_t                  ctl,
  output sts_t                  sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output rsp_t                  rsp
);

  localparam int WORDS = (ID_COUNT + 63) / 64;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IDW   = $clog2(ID_COUNT);
  localparam int LW    = $clog2(ID_COUNT + 1);
  localparam int CW    = (LW > 12) ? LW : 12;

  logic [11:0] id_limit;
  logic [63:0] file_base_addr;
  logic [4:0]  hart_stride_shift;
  logic [4:0]  hart_count;

  req_t            req_q;
  logic [LW-1:0]   pos, run, s_id, e_id, t_id;
  logic [WAW-1:0]  mw;
  logic [63:0]     word;
  logic [IDW-1:0]  clr_cnt;
  logic [WORDS-1:0] wvalid;
  logic [WAW-1:0]  map_raddr_q;

  logic            map_we;
  logic [WAW-1:0]  map_raddr, map_waddr;
  logic [63:0]     map_wdata, map_rdata, map_word;
  logic            tbl_we;
  logic [IDW-1:0]  tbl_addr;
  logic [TBL_W-1:0] tbl_wdata, tbl_rdata;

  logic [LW-1:0]   lim, run_v, idx_v, fs_v, fe_v;
  logic            found_v, stop_v, exhausted;
  logic [WAW-1:0]  ident_word, s_word, e_word;
  logic [IDW-1:0]  ident_idx;
  logic            id_bad, set_ok, bit_free, cmp_ok;
  logic [5:0]      lo, hi;
  logic [63:0]     mark_mask, cmp_addr;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      id_limit          <= ID_LIMIT_RST;
      file_base_addr    <= FILE_BASE_RST;
      hart_stride_shift <= STRIDE_SHIFT_RST;
      hart_count        <= HART_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ID_LIMIT:     id_limit          <= cfg_data[11:0];
        CFG_FILE_BASE:    file_base_addr    <= cfg_data;
        CFG_STRIDE_SHIFT: hart_stride_shift <= cfg_data[4:0];
        CFG_HART_COUNT:   hart_count        <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign ident_word = WAW'({21'b0, req_q.ident} >> 6);
  assign ident_idx  = IDW'(req_q.ident);
  assign s_word     = WAW'(s_id >> 6);
  assign e_word     = WAW'(e_id >> 6);
  assign id_bad     = !({21'b0, req_q.ident} < 32'(ID_COUNT));
  assign set_ok     = !id_bad && ({1'b0, req_q.hart} < hart_count)
                      && ({28'b0, req_q.hart} < 32'(HART_COUNT));
  assign lim        = (CW'(id_limit) > CW'(ID_COUNT)) ? LW'(ID_COUNT) : LW'(id_limit);

  // Words never written read as their reset value: only identity zero used.
  assign map_word = wvalid[map_raddr_q] ? map_rdata
                  : ((map_raddr_q == '0) ? 64'd1 : 64'd0);
  assign bit_free = !map_word[req_q.ident[5:0]];

  // Eight identities are examined per cycle from the loaded word.
  always_comb begin
    run_v   = run;
    found_v = 1'b0;
    stop_v  = 1'b0;
    fs_v    = '0;
    fe_v    = '0;
    idx_v   = pos;
    for (int k = 0; k < 8; k++) begin
      idx_v = pos + LW'(k);
      if (!found_v && !stop_v) begin
        if (idx_v >= lim) begin
          stop_v = 1'b1;
        end else if (word[{pos[5:3], 3'(k)}]) begin
          run_v = '0;
        end else begin
          run_v = run_v + LW'(1);
          if (CW'(run_v) == CW'(req_q.run_length)) begin
            found_v = 1'b1;
            fe_v    = idx_v;
            fs_v    = idx_v + LW'(1) - LW'(req_q.run_length);
          end
        end
      end
    end
  end
  assign exhausted = ({1'b0, pos} + (LW + 1)'(8)) >= {1'b0, lim};

  assign lo        = (mw == s_word) ? s_id[5:0] : 6'd0;
  assign hi        = (mw == e_word) ? e_id[5:0] : 6'd63;
  assign mark_mask = ({64{1'b1}} << lo) & ({64{1'b1}} >> (6'd63 - hi));

  assign cmp_ok   = tbl_rdata[TBL_W-1] && ({1'b0, tbl_rdata[3:0]} < hart_count)
                    && ({28'b0, tbl_rdata[3:0]} < 32'(HART_COUNT));
  assign cmp_addr = file_base_addr + ({60'b0, tbl_rdata[3:0]} << hart_stride_shift);

  // Memory port selection.
  always_comb begin
    map_raddr = ident_word;
    if (ctl.scan_rd) begin
      map_raddr = WAW'(pos >> 6);
    end else if (ctl.mark_rd) begin
      map_raddr = mw;
    end
    map_we    = ctl.mark_wr || (ctl.res_chk && bit_free);
    map_waddr = ctl.mark_wr ? mw : ident_word;
    map_wdata = ctl.mark_wr ? (map_word | mark_mask)
                            : (map_word | (64'd1 << req_q.ident[5:0]));

    tbl_addr  = ident_idx;
    tbl_wdata = {1'b1, req_q.hart};
    if (ctl.clr_step) begin
      tbl_addr  = clr_cnt;
      tbl_wdata = '0;
    end else if (ctl.tgt_step) begin
      tbl_addr  = IDW'(t_id);
      tbl_wdata = {1'b1, 4'd0};
    end
    tbl_we = ctl.clr_step || ctl.tgt_step || (ctl.tbl_set && set_ok);
  end

  mira_ram #(.WIDTH(64), .DEPTH(WORDS)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  mira_ram #(.WIDTH(TBL_W), .DEPTH(ID_COUNT)) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_addr),
    .wdata (tbl_wdata),
    .raddr (tbl_addr),
    .rdata (tbl_rdata)
  );

  always_ff @(posedge clk) begin
    map_raddr_q <= map_raddr;
    if (ctl.latch) req_q <= req;
    if (ctl.scan_ld) word <= map_word;
    if (ctl.scan_init) begin
      pos <= '0;
      run <= '0;
    end else if (ctl.scan_step) begin
      pos <= pos + LW'(8);
      run <= run_v;
    end
    if (ctl.scan_step && found_v) begin
      s_id <= fs_v;
      e_id <= fe_v;
      t_id <= fs_v;
      mw   <= WAW'(fs_v >> 6);
    end else begin
      if (ctl.mark_wr) mw <= mw + WAW'(1);
      if (ctl.tgt_step) t_id <= t_id + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      wvalid  <= '0;
    end else begin
      if (ctl.clr_step) clr_cnt <= clr_cnt + IDW'(1);
      if (map_we) wvalid[map_waddr] <= 1'b1;
    end
  end

  // Result register: one strobe per finished command.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (ctl.fin != FIN_NONE);
    end
    if (ctl.fin != FIN_NONE) begin
      rsp.ok       <= 1'b0;
      rsp.first_id <= req_q.ident;
      rsp.msg_addr <= 64'd0;
      case (ctl.fin)
        FIN_ALLOC_FAIL: rsp.first_id <= 11'd0;
        FIN_ALLOC_OK: begin
          rsp.ok       <= 1'b1;
          rsp.first_id <= 11'(s_id);
        end
        FIN_SET: rsp.ok <= set_ok;
        FIN_RES: rsp.ok <= bit_free;
        FIN_CMP: begin
          rsp.ok       <= cmp_ok;
          rsp.msg_addr <= cmp_ok ? cmp_addr : 64'd0;
        end
        default: ;
      endcase
    end
  end

  assign sts.cmd       = req_q.cmd;
  assign sts.clr_last  = (clr_cnt == IDW'(ID_COUNT - 1));
  assign sts.len_zero  = (req_q.run_length == 12'd0);
  assign sts.id_bad    = id_bad;
  assign sts.found     = found_v;
  assign sts.fail      = stop_v || exhausted;
  assign sts.word_end  = (pos[5:3] == 3'b111);
  assign sts.mark_last = (mw == e_word);
  assign sts.tgt_last  = (t_id == e_id);

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");
  a_mark_in_run: assert property (@(posedge clk) disable iff (rst)
    ctl.mark_wr |-> (mw >= s_word && mw <= e_word))
    else $error("marking pass wrote outside the found run");
  a_tgt_in_run: assert property (@(posedge clk) disable iff (rst)
    ctl.tgt_step |-> (t_id >= s_id && t_id <= e_id))
    else $error("target write outside the found run");

endmodule
